FILE: rtl/bzb_pkg.sv
// Shared types, constants and helpers for the Bezier easing bisection core.
// No dependencies; imported by bzb_eval and bezier_easing_bisection_core.
package bzb_pkg;

	// number of bisection steps (1..15)
	localparam int BISECT_STEPS = 8;

	localparam logic [15:0] T_HALF  = 16'h8000;   // t = 0.5 in Q0.16
	localparam logic [15:0] Q15_ONE = 16'h8000;   // 1.0 in Q1.15

	// tolerance 3*2^-15 at the Bx scale of 127*2^48
	localparam logic [55:0] TOL_SCALED = 56'd381 << 33;
	// half an output LSB at the By scale, for round-half-up
	localparam logic [54:0] RND_BIAS   = 55'd127 << 32;
	// floor(2^29 / 127), for the divide by 127 after the 2^33 shift
	localparam logic [22:0] RECIP_127  = 23'd4227330;

	// Bezier expanded in T: inner = k0*2^32 + k1*T*2^16 + k2*T^2, B = inner*T
	typedef struct packed {
		logic        [8:0]  k0;   // 3*c1
		logic signed [10:0] k1;   // 3*c2 - 6*c1
		logic signed [9:0]  k2;   // 3*c1 - 3*c2 + 127
	} bzb_coef_t;

	typedef struct packed {
		bzb_coef_t   cx;
		bzb_coef_t   cy;
		logic [21:0] tgt;   // saturated x * 127, target = tgt << 33
		logic        done;  // search has stopped early
	} bzb_ctx_t;

	function automatic bzb_coef_t make_coef(input logic [6:0] c1, input logic [6:0] c2);
		bzb_coef_t   k;
		logic [10:0] c1w;
		logic [10:0] c2w;
		logic [10:0] k2w;
		c1w  = {4'b0000, c1};
		c2w  = {4'b0000, c2};
		k2w  = c1w * 11'd3 - c2w * 11'd3 + 11'd127;
		k.k0 = c1w[8:0] * 9'd3;
		k.k1 = c2w * 11'd3 - c1w * 11'd6;
		k.k2 = k2w[9:0];
		return k;
	endfunction

endpackage

FILE: rtl/bezier_easing_bisection_core.sv
// Top level of the cubic Bezier easing core with a bisection solver.
// Depends on bzb_pkg and bzb_eval.
//
// Maps a time fraction x (Q1.15, saturated to 1.0) through an easing curve
// from (0,0) to (1,1) with control points (ctrl_x1, ctrl_y1)/127 and
// (ctrl_x2, ctrl_y2)/127, returning By(t) in Q1.15 where Bx(t) = x. The
// search is fully unrolled: one request is taken every cycle unless the
// pipeline is stalled by a full output buffer. Each bisection step is five
// register stages (T squared, coefficient products, sum, times T, compare
// and move T), the final By evaluation takes four more, the divide by
// 127*2^33 with rounding three, plus the input register and the output
// register. Every step uses its own multipliers. A two-entry output
// buffer (output register plus skid) lets requests keep flowing while a
// result waits; the pipeline only stalls when both entries are full, and a
// stall freezes every stage in place.
module bezier_easing_bisection_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// [6:0] ctrl_x1, [13:7] ctrl_y1, [20:14] ctrl_x2, [27:21] ctrl_y2,
	// [43:28] time_fraction, [47:44] zero
	input  logic [47:0] s_axis_tdata,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// [15:0] eased_value
	output logic [15:0] m_axis_tdata
);
	import bzb_pkg::*;

	// bit of T that marks the last step when no early stop happened
	localparam int T_LSB = 15 - BISECT_STEPS;

	logic out_vld_q, skid_vld_q;
	logic adv;   // whole pipeline moves
	assign adv           = !skid_vld_q;
	assign s_axis_tready = adv;

	// ---------------- input register ----------------
	logic [6:0]  ctrl_x1, ctrl_y1, ctrl_x2, ctrl_y2;
	logic [15:0] time_fraction, xq_sat;
	logic [22:0] tgt_w;
	logic        vld_s1;
	bzb_ctx_t    ctx_s1;

	always_comb begin
		ctrl_x1       = s_axis_tdata[6:0];
		ctrl_y1       = s_axis_tdata[13:7];
		ctrl_x2       = s_axis_tdata[20:14];
		ctrl_y2       = s_axis_tdata[27:21];
		time_fraction = s_axis_tdata[43:28];
		// time above one saturates
		xq_sat        = (time_fraction > Q15_ONE) ? Q15_ONE : time_fraction;
		tgt_w         = {xq_sat, 7'b0} - {7'b0, xq_sat};   // x * 127
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ctx_s1.cx   <= make_coef(ctrl_x1, ctrl_x2);
			ctx_s1.cy   <= make_coef(ctrl_y1, ctrl_y2);
			ctx_s1.tgt  <= tgt_w[21:0];
			ctx_s1.done <= 1'b0;
		end
	end

	// ---------------- bisection steps ----------------
	logic        chain_vld [BISECT_STEPS+1];
	logic [15:0] chain_t   [BISECT_STEPS+1];
	bzb_ctx_t    chain_ctx [BISECT_STEPS+1];

	assign chain_vld[0] = vld_s1;
	assign chain_t[0]   = T_HALF;
	assign chain_ctx[0] = ctx_s1;

	for (genvar gi = 0; gi < BISECT_STEPS; gi++) begin : g_step
		localparam logic [15:0] STEP = 16'(1 << (14 - gi));

		logic        ev_vld;
		logic [15:0] ev_t;
		logic [54:0] ev_bx;
		bzb_ctx_t    ev_ctx;
		logic [55:0] bx_w, tg_w;
		logic        lt, stop;
		bzb_ctx_t    ctx_nx;
		logic        vld_s5;
		logic [15:0] t_s5;
		bzb_ctx_t    ctx_s5;

		bzb_eval u_eval (
			.clk     (clk),
			.arst_n  (arst_n),
			.en      (adv),
			.vld     (chain_vld[gi]),
			.t       (chain_t[gi]),
			.coef    (chain_ctx[gi].cx),
			.ctx     (chain_ctx[gi]),
			.vld_out (ev_vld),
			.t_out   (ev_t),
			.bx      (ev_bx),
			.ctx_out (ev_ctx)
		);

		always_comb begin
			bx_w = {1'b0, ev_bx};
			tg_w = {1'b0, ev_ctx.tgt, 33'd0};
			lt   = bx_w < tg_w;
			// |Bx - x| < tol, written as two one-sided compares
			stop = (bx_w + TOL_SCALED > tg_w) && (bx_w < tg_w + TOL_SCALED);
			ctx_nx      = ev_ctx;
			ctx_nx.done = ev_ctx.done | stop;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s5 <= 1'b0;
			end else if (adv) begin
				vld_s5 <= ev_vld;
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				ctx_s5 <= ctx_nx;
				if (ev_ctx.done || stop) begin
					t_s5 <= ev_t;
				end else if (lt) begin
					t_s5 <= ev_t + STEP;
				end else begin
					t_s5 <= ev_t - STEP;
				end
			end
		end

		assign chain_vld[gi+1] = vld_s5;
		assign chain_t[gi+1]   = t_s5;
		assign chain_ctx[gi+1] = ctx_s5;
	end

	// ---------------- By at the found T ----------------
	logic        fin_vld;
	logic [15:0] fin_t;
	logic [54:0] fin_by;
	bzb_ctx_t    fin_ctx;

	bzb_eval u_eval_y (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (adv),
		.vld     (chain_vld[BISECT_STEPS]),
		.t       (chain_t[BISECT_STEPS]),
		.coef    (chain_ctx[BISECT_STEPS].cy),
		.ctx     (chain_ctx[BISECT_STEPS]),
		.vld_out (fin_vld),
		.t_out   (fin_t),
		.bx      (fin_by),
		.ctx_out (fin_ctx)
	);

	// ---------------- round and divide by 127*2^33 ----------------
	// floor(floor(a / 2^33) / 127) by reciprocal, then one correction
	logic [54:0] rnd_a;
	logic        rnd_vld_s1, rnd_vld_s2, rnd_vld_s3;
	logic [21:0] rnd_h_s1, rnd_h_s2;
	logic [44:0] rnd_prod_s2;
	logic [15:0] rnd_q0;
	logic [22:0] rnd_r;
	logic [15:0] rnd_q0_s3;
	logic [8:0]  rnd_r_s3;
	logic [16:0] rnd_q;
	logic [15:0] res;
	logic        push;

	always_comb begin
		rnd_a  = fin_by + RND_BIAS;
		rnd_q0 = rnd_prod_s2[44:29];
		rnd_r  = {1'b0, rnd_h_s2} - ({rnd_q0, 7'b0} - {7'b0, rnd_q0});
		rnd_q  = {1'b0, rnd_q0_s3} + ((rnd_r_s3 >= 9'd127) ? 17'd1 : 17'd0);
		res    = (rnd_q > {1'b0, Q15_ONE}) ? Q15_ONE : rnd_q[15:0];
		push   = adv && rnd_vld_s3;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rnd_vld_s1 <= 1'b0;
			rnd_vld_s2 <= 1'b0;
			rnd_vld_s3 <= 1'b0;
		end else if (adv) begin
			rnd_vld_s1 <= fin_vld;
			rnd_vld_s2 <= rnd_vld_s1;
			rnd_vld_s3 <= rnd_vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rnd_h_s1    <= rnd_a[54:33];
			rnd_h_s2    <= rnd_h_s1;
			rnd_prod_s2 <= rnd_h_s1 * RECIP_127;
			rnd_q0_s3   <= rnd_q0;
			rnd_r_s3    <= rnd_r[8:0];
		end
	end

	// ---------------- output register and skid ----------------
	logic [15:0] out_data_q, skid_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q  <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (!out_vld_q || m_axis_tready) begin
			if (skid_vld_q) begin
				out_vld_q  <= 1'b1;
				out_data_q <= skid_data_q;
				skid_vld_q <= 1'b0;
			end else begin
				out_vld_q <= push;
				if (push) begin
					out_data_q <= res;
				end
			end
		end else if (push) begin
			skid_vld_q  <= 1'b1;
			skid_data_q <= res;
		end
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = out_data_q;

	// ---------------- assertions ----------------
	// skid only fills behind a held output
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_vld_q |-> out_vld_q)
		else $error("skid holds a result while the output register is empty");

	// result never above 1.0
	a_res_max: assert property (@(posedge clk) disable iff (!arst_n)
		out_vld_q |-> (out_data_q <= Q15_ONE))
		else $error("eased value above one");

	// reciprocal estimate is at most one short
	a_rnd_rem: assert property (@(posedge clk) disable iff (!arst_n)
		rnd_vld_s3 |-> (rnd_r_s3 < 9'd254))
		else $error("divide-by-127 remainder out of range");

	// a search that ran all steps ends on the last step's bit
	a_full_search: assert property (@(posedge clk) disable iff (!arst_n)
		(fin_vld && !fin_ctx.done) |-> fin_t[T_LSB])
		else $error("final T inconsistent with a full bisection");

	// a stall freezes the result stage
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!adv && rnd_vld_s3) |=> (rnd_vld_s3 && $stable(rnd_q0_s3)))
		else $error("result stage moved during a stall");

endmodule

FILE: rtl/bzb_eval.sv
// Four-stage pipelined evaluation of one cubic Bezier coordinate at T.
// Depends on bzb_pkg for the coefficient and context types.
module bzb_eval (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               vld,
	input  logic [15:0]        t,
	input  bzb_pkg::bzb_coef_t coef,
	input  bzb_pkg::bzb_ctx_t  ctx,
	output logic               vld_out,
	output logic [15:0]        t_out,
	output logic [54:0]        bx,
	output bzb_pkg::bzb_ctx_t  ctx_out
);
	import bzb_pkg::*;

	logic        vld_s1, vld_s2, vld_s3, vld_s4;
	logic [15:0] t_s1, t_s2, t_s3, t_s4;
	bzb_coef_t   coef_s1, coef_s2;
	bzb_ctx_t    ctx_s1, ctx_s2, ctx_s3, ctx_s4;
	logic [31:0] sq_s1;
	logic signed [27:0] p1, p1_s2;
	logic signed [41:0] p2, p2_s2;
	logic [43:0] inner_w;
	logic [40:0] inner_s3;
	logic [56:0] prod;
	logic [54:0] bx_s4;

	always_comb begin
		p1      = $signed({1'b0, t_s1}) * $signed(coef_s1.k1);
		p2      = $signed({1'b0, sq_s1}) * $signed(coef_s1.k2);
		// inner is nonnegative and below 381*2^32
		inner_w = {3'b000, coef_s2.k0, 32'd0} + {p1_s2, 16'd0} + {{2{p2_s2[41]}}, p2_s2};
		prod    = inner_s3 * t_s3;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else if (en) begin
			vld_s1 <= vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			t_s1     <= t;
			coef_s1  <= coef;
			ctx_s1   <= ctx;
			sq_s1    <= t * t;
			t_s2     <= t_s1;
			coef_s2  <= coef_s1;
			ctx_s2   <= ctx_s1;
			p1_s2    <= p1;
			p2_s2    <= p2;
			t_s3     <= t_s2;
			ctx_s3   <= ctx_s2;
			inner_s3 <= inner_w[40:0];
			t_s4     <= t_s3;
			ctx_s4   <= ctx_s3;
			bx_s4    <= prod[54:0];
		end
	end

	assign vld_out = vld_s4;
	assign t_out   = t_s4;
	assign bx      = bx_s4;
	assign ctx_out = ctx_s4;

endmodule

FILE: tb/tb_bezier_easing_bisection_core.sv
`timescale 1ns / 1ps
// Self-checking testbench for bezier_easing_bisection_core: directed corners,
// random curves and back-to-back streams against an exact integer predictor.
// Depends on the RTL only (bzb_pkg for the bisection step count).
module tb_bezier_easing_bisection_core;

	// one request, packed as it travels on s_axis_tdata[43:0]
	typedef struct packed {
		logic [15:0] time_fraction;
		logic [6:0]  ctrl_y2;
		logic [6:0]  ctrl_x2;
		logic [6:0]  ctrl_y1;
		logic [6:0]  ctrl_x1;
	} easing_req_t;

	localparam bit [63:0] Q15_FULL    = 64'd32768;
	localparam bit [63:0] T_FULL      = 64'd65536;
	// x in Q1.15 lifted to the curve scale of 127 * 2^48
	localparam bit [63:0] X_LIFT      = 64'd127 << 33;
	localparam bit [63:0] STOP_WINDOW = 64'd381 << 33;
	localparam bit [63:0] HALF_LSB    = 64'd127 << 32;
	localparam int        IDLE_LIMIT  = 2000;
	localparam int        DRAIN_WAIT  = 60;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [47:0] s_axis_tdata = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [15:0] m_axis_tdata;

	logic [15:0] eased_q[$];
	bit          steady_flow = 1'b0;
	int          rx_hold = 0;
	int          rx_pause;
	int          idle_cycles = 0;
	int          requests_taken = 0;
	int          past_one_taken = 0;
	int          results_checked = 0;
	int          mismatches = 0;

	bezier_easing_bisection_core dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// 3*S^2*T*c1 + 3*S*T^2*c2 + 127*T^3, T = t * 2^16
	function automatic bit [63:0] curve_scaled(bit [63:0] t_q16, bit [63:0] c1,
		bit [63:0] c2);
		bit [63:0] s_q16;
		s_q16 = T_FULL - t_q16;
		return 64'd3 * s_q16 * s_q16 * t_q16 * c1 + 64'd3 * s_q16 * t_q16 * t_q16 * c2
			+ 64'd127 * t_q16 * t_q16 * t_q16;
	endfunction

	function automatic logic [15:0] eased_value_of(easing_req_t r);
		bit [63:0] x_q15;
		bit [63:0] goal;
		bit [63:0] t_q16;
		bit [63:0] bx;
		bit [63:0] miss;
		bit [63:0] move;
		bit [63:0] y_q15;
		bit        settled;
		settled = 1'b0;
		x_q15 = (r.time_fraction > Q15_FULL) ? Q15_FULL : 64'(r.time_fraction);
		goal = x_q15 * X_LIFT;
		t_q16 = 64'd32768;
		for (int k = 0; k < bzb_pkg::BISECT_STEPS; k++) begin
			if (!settled) begin
				bx = curve_scaled(t_q16, 64'(r.ctrl_x1), 64'(r.ctrl_x2));
				miss = (bx >= goal) ? bx - goal : goal - bx;
				move = (k <= 14) ? (64'd1 << (14 - k)) : 64'd0;
				if (miss < STOP_WINDOW)
					settled = 1'b1;
				else if (bx < goal)
					t_q16 = t_q16 + move;
				else
					t_q16 = t_q16 - move;
			end
		end
		y_q15 = (curve_scaled(t_q16, 64'(r.ctrl_y1), 64'(r.ctrl_y2)) + HALF_LSB) / X_LIFT;
		if (y_q15 > Q15_FULL)
			y_q15 = Q15_FULL;
		return y_q15[15:0];
	endfunction

	function automatic easing_req_t make_req(int x1, int y1, int x2, int y2, int tf);
		easing_req_t r;
		r.ctrl_x1 = x1[6:0];
		r.ctrl_y1 = y1[6:0];
		r.ctrl_x2 = x2[6:0];
		r.ctrl_y2 = y2[6:0];
		r.time_fraction = tf[15:0];
		return r;
	endfunction

	// control byte: mostly uniform, sometimes pinned to an end of the range
	function automatic int pick_ctrl();
		case ($urandom_range(0, 7))
			0: return 0;
			1: return 127;
			default: return $urandom_range(0, 127);
		endcase
	endfunction

	function automatic int pick_time();
		case ($urandom_range(0, 9))
			0: return $urandom_range(32769, 65535);
			1: begin
				case ($urandom_range(0, 4))
					0: return 0;
					1: return 1;
					2: return 32767;
					3: return 32768;
					default: return 65535;
				endcase
			end
			default: return $urandom_range(0, 32768);
		endcase
	endfunction

	function automatic easing_req_t random_req();
		return make_req(pick_ctrl(), pick_ctrl(), pick_ctrl(), pick_ctrl(), pick_time());
	endfunction

	// drive one request after a gap, hold it until the core takes it
	task automatic send_request(easing_req_t r, int gap);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {4'b0000, r};
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
	endtask

	task automatic note_failure(string what, logic [15:0] want, logic [15:0] got);
		mismatches++;
		if (mismatches <= 10)
			$display("[%0t] %s: expected eased_value %0d, got %0d", $realtime, what,
				want, got);
	endtask

	// corners: flat and full curves, x at 0 / 1 / above 1, exact hit at t=0.5,
	// the stop window edge, and both search directions
	task automatic test_corner_curves();
		easing_req_t list[$];
		list.push_back(make_req(0, 0, 0, 0, 0));
		list.push_back(make_req(127, 127, 127, 127, 32768));
		list.push_back(make_req(0, 0, 0, 0, 32768));
		list.push_back(make_req(127, 127, 127, 127, 0));
		list.push_back(make_req(0, 0, 127, 127, 16384));
		list.push_back(make_req(0, 0, 127, 127, 16385));
		list.push_back(make_req(0, 0, 127, 127, 16386));
		list.push_back(make_req(0, 0, 127, 127, 16387));
		list.push_back(make_req(0, 127, 127, 0, 16384));
		list.push_back(make_req(127, 0, 0, 127, 16383));
		list.push_back(make_req(64, 10, 64, 120, 32769));
		list.push_back(make_req(20, 100, 90, 5, 65535));
		list.push_back(make_req(42, 42, 85, 85, 1));
		list.push_back(make_req(42, 42, 85, 85, 32767));
		list.push_back(make_req(127, 0, 127, 0, 8000));
		list.push_back(make_req(0, 127, 0, 127, 25000));
		list.push_back(make_req(100, 30, 27, 97, 40000));
		list.push_back(make_req(127, 127, 0, 0, 12345));
		list.push_back(make_req(1, 126, 126, 1, 20000));
		list.push_back(make_req(85, 0, 42, 127, 32768));
		list.push_back(make_req(0, 0, 0, 0, 16384));
		list.push_back(make_req(127, 127, 127, 127, 16384));
		foreach (list[i])
			send_request(list[i], $urandom_range(0, 17));
	endtask

	// random curves with random gaps, broken up by stretches of full rate
	task automatic test_random_curves(int count);
		bit burst;
		burst = 1'b0;
		for (int n = 0; n < count; n++) begin
			if (n % 40 == 0) begin
				burst = ($urandom_range(0, 3) == 0);
				steady_flow <= ($urandom_range(0, 3) == 0);
			end
			send_request(random_req(), burst ? 0 : $urandom_range(0, 17));
		end
	endtask

	// full rate on both sides: every pipeline stage busy at once
	task automatic test_back_to_back(int count);
		steady_flow <= 1'b1;
		for (int n = 0; n < count; n++)
			send_request(random_req(), 0);
		steady_flow <= 1'b0;
	endtask

	// expectation per accepted request
	always @(posedge clk) begin
		if (arst_n && s_axis_tvalid && s_axis_tready) begin
			eased_q.push_back(eased_value_of(easing_req_t'(s_axis_tdata[43:0])));
			requests_taken++;
			if (s_axis_tdata[43:28] > 16'd32768)
				past_one_taken++;
		end
	end

	// compare each result with the oldest expectation
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			results_checked++;
			if (eased_q.size() == 0)
				note_failure("result with no request pending", 16'd0, m_axis_tdata);
			else if (eased_q[0] !== m_axis_tdata) begin
				note_failure("eased_value mismatch", eased_q[0], m_axis_tdata);
				void'(eased_q.pop_front());
			end else
				void'(eased_q.pop_front());
		end
	end

	// result side: random stall after each result unless running steady
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			rx_hold <= 0;
		end else if (m_axis_tvalid && m_axis_tready) begin
			rx_pause = steady_flow ? 0 : $urandom_range(0, 17);
			if (rx_pause != 0) begin
				m_axis_tready <= 1'b0;
				rx_hold <= rx_pause - 1;
			end
		end else if (!m_axis_tready) begin
			if (rx_hold == 0)
				m_axis_tready <= 1'b1;
			else
				rx_hold <= rx_hold - 1;
		end
	end

	// watchdog on cycles with no handshake on either side
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("timeout: %0d cycles without a handshake, %0d results pending",
				idle_cycles, eased_q.size());
			$display("FAIL bezier_easing_bisection_core");
			$finish;
		end
	end

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_corner_curves();
		test_random_curves(680);
		test_back_to_back(120);
		s_axis_tvalid <= 1'b0;
		while (eased_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
		$display("covered %0d requests (%0d with x past 1.0), corner and random curves",
			requests_taken, past_one_taken);
		$display("checked %0d results, %0d mismatches", results_checked, mismatches);
		if (mismatches == 0 && eased_q.size() == 0)
			$display("PASS bezier_easing_bisection_core");
		else
			$display("FAIL bezier_easing_bisection_core");
		$finish;
	end

endmodule

FILE: filelist.f
rtl/bzb_pkg.sv
rtl/bzb_eval.sv
rtl/bezier_easing_bisection_core.sv
tb/tb_bezier_easing_bisection_core.sv
